FILE: hw/rtl/kts_pkg.sv
// shared widths, codes and types of the k-ary tree slot table
`default_nettype none

package kts_pkg;

  localparam int OP_W       = 3;
  localparam int SLOT_W     = 12;
  localparam int LEVEL_W    = 4;
  localparam int POS_W      = 12;
  localparam int STATUS_W   = 3;
  localparam int OFFSET_W   = 28;
  localparam int COUNT_W    = 13;
  localparam int ARITY_W    = 13;
  localparam int LEVELS_W   = 4;
  localparam int EBYTES_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int WORD_BITS  = 64;
  localparam int BIT_SEL_W  = 6;

  localparam int DEF_SLOT_COUNT = 4096;
  localparam int DEF_MAX_LEVELS = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_ARITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EBYTES = 2'd2;

  localparam logic [ARITY_W-1:0]  ARITY_RST  = 13'd2;
  localparam logic [LEVELS_W-1:0] LEVELS_RST = 4'd1;
  localparam logic [EBYTES_W-1:0] EBYTES_RST = 16'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 3'd0,
    OP_ADD_OR_GET = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_GET        = 3'd3,
    OP_CONTAINS   = 3'd4,
    OP_LOCATE     = 3'd5
  } kts_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_OOB     = 3'd1,
    STAT_NOT_OCC = 3'd2,
    STAT_ALREADY = 3'd3,
    STAT_CFG     = 3'd4
  } kts_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } kts_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kts_if.sv
// channel interfaces: operation in, result out, register writes
`default_nettype none

interface kts_in_if;
  import kts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [SLOT_W-1:0]    slot;
  logic [LEVEL_W-1:0]   level;
  logic [POS_W-1:0]     position;
  modport source (output valid, op, slot, level, position, input ready);
  modport sink   (input valid, op, slot, level, position, output ready);
endinterface

interface kts_out_if;
  import kts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot_index;
  logic [OFFSET_W-1:0]  byte_offset;
  logic                 present;
  logic [COUNT_W-1:0]   occupied_count;
  modport source (output valid, status, slot_index, byte_offset, present, occupied_count,
                  input ready);
  modport sink   (input valid, status, slot_index, byte_offset, present, occupied_count,
                  output ready);
endinterface

interface kts_cfg_if;
  import kts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kts_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module kts_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kary_tree_slot_table_unit.sv
// slot occupancy table for a complete k-ary tree stored level by level
//
// in_bus takes one operation per beat (add, add-or-get, remove, get, contains,
// locate); out_bus returns exactly one result beat for each. cfg_bus writes
// arity, levels and element size and is always ready; write it only while no
// operation is in flight.
// an operation reads its bitmap word at acceptance, then walks the tree levels
// one per cycle through a saturating multiply-accumulate to find capacity and
// the locate base, then decides and writes the word back in the finishing state.
// in_bus is ready only in the idle state, so a new operation is not taken
// until the previous one has been through the serial per-level arity
// multiply and has finished.
// the result sits in an output register: the next operation is taken while it
// waits, but finishing that next one stalls until the receiver takes the
// previous beat.
// reset: the bitmap ram is cleared one 64-bit word a cycle, all SLOT_COUNT/64
// words (64 at default size), with in_bus not ready; count goes to zero and
// registers to arity 2, levels 1, element size 1.
`default_nettype none

module kary_tree_slot_table_unit #(
  parameter int SLOT_COUNT = kts_pkg::DEF_SLOT_COUNT,
  parameter int MAX_LEVELS = kts_pkg::DEF_MAX_LEVELS
) (
  input wire logic clk,
  input wire logic rst_n,
  kts_in_if.sink   in_bus,
  kts_out_if.source out_bus,
  kts_cfg_if.sink  cfg_bus
);
  import kts_pkg::*;

  localparam int WORD_TOTAL = SLOT_COUNT / WORD_BITS;
  localparam int AW = (WORD_TOTAL > 1) ? $clog2(WORD_TOTAL) : 1;
  localparam int SW = $clog2(SLOT_COUNT + 2);
  localparam int PW = SW + ARITY_W;
  localparam logic [PW-1:0] SAT_P = PW'(SLOT_COUNT + 1);
  localparam logic [SW:0]   SAT_S = (SW + 1)'(SLOT_COUNT + 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(WORD_TOTAL - 1);

  kts_state_t state_r, state_nxt;

  logic [ARITY_W-1:0]  arity_r;
  logic [LEVELS_W-1:0] levels_r;
  logic [EBYTES_W-1:0] ebytes_r;

  logic [OP_W-1:0]    op_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [LEVEL_W-1:0] level_r;
  logic [POS_W-1:0]   pos_r;

  logic [SW-1:0]       acc_r, pw_r, base_r, row_r;
  logic [LEVELS_W-1:0] n_r;
  logic [AW-1:0]       clr_r;
  logic [COUNT_W-1:0]  count_r, count_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic                out_present_r;

  logic                in_fire, fin_go, lvl_bad, step_last;
  logic [PW-1:0]       prod;
  logic [SW:0]         sum;
  logic [SW-1:0]       acc_step, pw_step;

  kts_status_t         res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [OFFSET_W-1:0] res_offset, offset_full;
  logic                res_present;
  logic [31:0]         loc_sum;

  logic                   mem_we, bit_set;
  logic [AW-1:0]          mem_waddr, word_addr;
  logic [WORD_BITS-1:0]   mem_wdata, word_rd, bit_mask;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_bus.ready);

  assign out_bus.valid          = out_valid_r;
  assign out_bus.status         = out_status_r;
  assign out_bus.slot_index     = out_slot_r;
  assign out_bus.byte_offset    = out_offset_r;
  assign out_bus.present        = out_present_r;
  assign out_bus.occupied_count = count_r;

  kts_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_TOTAL)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (AW'(in_bus.slot[SLOT_W-1:BIT_SEL_W])),
    .rdata (word_rd)
  );

  // one level of the saturating geometric series
  assign prod     = PW'(pw_r) * PW'(arity_r);
  assign sum      = (SW + 1)'(acc_r) + (SW + 1)'(pw_r);
  assign pw_step  = (prod > SAT_P) ? SW'(SAT_P) : SW'(prod);
  assign acc_step = (sum > SAT_S) ? SW'(SAT_S) : SW'(sum);
  assign lvl_bad  = 32'(levels_r) > MAX_LEVELS;
  assign step_last = (n_r + LEVELS_W'(1)) == levels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (lvl_bad || n_r == levels_r || step_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arity_r  <= ARITY_RST;
      levels_r <= LEVELS_RST;
      ebytes_r <= EBYTES_RST;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      unique case (cfg_bus.index)
        CFG_ARITY:  arity_r  <= cfg_bus.data[ARITY_W-1:0];
        CFG_LEVELS: levels_r <= cfg_bus.data[LEVELS_W-1:0];
        CFG_EBYTES: ebytes_r <= cfg_bus.data[EBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (state_r == ST_CLEAR) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  // item fields and the per-level walk
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_bus.op;
      slot_r  <= in_bus.slot;
      level_r <= in_bus.level;
      pos_r   <= in_bus.position;
      acc_r   <= '0;
      pw_r    <= SW'(1);
      n_r     <= '0;
    end else if (state_r == ST_CALC && !lvl_bad && n_r != levels_r) begin
      if (n_r == level_r) begin
        base_r <= acc_r;
        row_r  <= pw_r;
      end
      acc_r <= acc_step;
      pw_r  <= pw_step;
      n_r   <= n_r + LEVELS_W'(1);
    end
  end

  assign word_addr   = AW'(slot_r[SLOT_W-1:BIT_SEL_W]);
  assign bit_mask    = WORD_BITS'(1) << slot_r[BIT_SEL_W-1:0];
  assign bit_set     = word_rd[slot_r[BIT_SEL_W-1:0]];
  assign offset_full = OFFSET_W'(slot_r) * OFFSET_W'(ebytes_r);
  assign loc_sum     = 32'(base_r) + 32'(pos_r);

  always_comb begin
    res_status  = STAT_OK;
    res_slot    = '0;
    res_offset  = '0;
    res_present = 1'b0;
    count_nxt   = count_r;
    mem_we      = 1'b0;
    mem_waddr   = word_addr;
    mem_wdata   = word_rd | bit_mask;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (lvl_bad || 32'(acc_r) > SLOT_COUNT) begin
      res_status = STAT_CFG;
    end else if (op_r == OP_LOCATE) begin
      if (level_r >= levels_r || 32'(pos_r) >= 32'(row_r)) begin
        res_status = STAT_OOB;
      end else begin
        res_slot = loc_sum[SLOT_W-1:0];
      end
    end else if (32'(op_r) > 32'(OP_LOCATE) || 32'(slot_r) >= 32'(acc_r)) begin
      res_status = STAT_OOB;
    end else begin
      unique case (op_r)
        OP_ADD: begin
          if (bit_set) begin
            res_status = STAT_ALREADY;
          end else begin
            mem_we     = fin_go;
            count_nxt  = count_r + COUNT_W'(1);
            res_slot   = slot_r;
            res_offset = offset_full;
          end
        end
        OP_ADD_OR_GET: begin
          if (!bit_set) begin
            mem_we    = fin_go;
            count_nxt = count_r + COUNT_W'(1);
          end
          res_slot   = slot_r;
          res_offset = offset_full;
        end
        OP_REMOVE: begin
          if (!bit_set) begin
            res_status = STAT_NOT_OCC;
          end else begin
            mem_we    = fin_go;
            mem_wdata = word_rd & ~bit_mask;
            count_nxt = count_r - COUNT_W'(1);
            res_slot  = slot_r;
          end
        end
        OP_GET: begin
          if (!bit_set) begin
            res_status = STAT_NOT_OCC;
          end else begin
            res_slot   = slot_r;
            res_offset = offset_full;
          end
        end
        default: begin
          res_slot    = slot_r;
          res_present = bit_set;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_status_r  <= res_status;
      out_slot_r    <= res_slot;
      out_offset_r  <= res_offset;
      out_present_r <= res_present;
    end
  end

`ifndef SYNTH
  a_count_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    !fin_go |=> $stable(count_r))
    else $error("occupied count moved outside the finishing cycle");

  a_count_step_one: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> (count_r == $past(count_r) || count_r == $past(count_r) + COUNT_W'(1)
                || count_r == $past(count_r) - COUNT_W'(1)))
    else $error("occupied count changed by more than one");

  a_write_when_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || fin_go))
    else $error("bitmap written outside clearing or finishing");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised without a finished operation");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_fire)
    else $error("operation taken during bitmap clear");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// self-checking testbench of the k-ary tree slot table: directed table, then random phases
module tb_top;
  import kts_pkg::*;

  localparam int unsigned SPAN_SAT = DEF_SLOT_COUNT + 1;
  localparam int FAIL_PRINT_MAX = 200;
  localparam int PHASES = 14;
  localparam int PRESETS = 12;
  localparam int ITEMS_PER_PHASE = 64;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT = 3000000;

  // tree shapes for the first phases: deepest, widest, too large, degenerate arity
  localparam int PRE_ARITY [0:PRESETS-1] = '{2, 3, 4095, 64, 2, 16, 4096, 1, 0, 5, 7, 2};
  localparam int PRE_LEVELS [0:PRESETS-1] = '{12, 3, 2, 2, 4, 3, 2, 12, 4, 0, 5, 13};
  localparam int PRE_EBYTES [0:PRESETS-1] = '{65535, 7, 1, 100, 0, 65535, 5, 2, 9, 1, 3, 1};

  typedef struct {
    kts_status_t        status;
    logic [SLOT_W-1:0]   slot_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic                present;
    logic [COUNT_W-1:0]  occupied_count;
  } slot_result_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [OP_W-1:0]       op;
    logic [SLOT_W-1:0]     slot;
    logic [LEVEL_W-1:0]    level;
    logic [POS_W-1:0]      position;
    bit                    typed;
    slot_result_t          want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  kts_in_if  op_ch ();
  kts_out_if res_ch ();
  kts_cfg_if cfg_ch ();

  kary_tree_slot_table_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (op_ch),
    .out_bus (res_ch),
    .cfg_bus (cfg_ch)
  );

  // shadow of the table
  bit                   occ_map [0:DEF_SLOT_COUNT-1];
  logic [COUNT_W-1:0]   occ_total = '0;
  logic [ARITY_W-1:0]   tbl_arity = ARITY_RST;
  logic [LEVELS_W-1:0]  tbl_levels = LEVELS_RST;
  logic [EBYTES_W-1:0]  tbl_ebytes = EBYTES_RST;

  slot_result_t pending_results [$];
  int fail_count = 0;
  int sent_items = 0;
  int send_idle = 14;
  int recv_idle = 72;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // slots in the first depth levels, saturating; row_width is arity^depth
  function automatic int unsigned tree_span(int unsigned depth, output int unsigned row_width);
    int unsigned acc;
    int unsigned pw;
    acc = 0;
    pw = 1;
    for (int unsigned n = 0; n < depth; n++) begin
      acc += pw;
      if (acc > SPAN_SAT) acc = SPAN_SAT;
      pw = pw * tbl_arity;
      if (pw > SPAN_SAT) pw = SPAN_SAT;
    end
    row_width = pw;
    return acc;
  endfunction

  function automatic slot_result_t predict_slot_result(logic [OP_W-1:0] op,
                                                       logic [SLOT_W-1:0] slot,
                                                       logic [LEVEL_W-1:0] level,
                                                       logic [POS_W-1:0] position);
    slot_result_t        r;
    int unsigned         cap;
    int unsigned         row;
    int unsigned         base;
    bit                  hit;
    logic [OFFSET_W-1:0] off;
    r.status = STAT_OK;
    r.slot_index = '0;
    r.byte_offset = '0;
    r.present = 1'b0;
    off = OFFSET_W'(slot) * OFFSET_W'(tbl_ebytes);
    cap = tree_span(tbl_levels, row);
    if (tbl_levels > DEF_MAX_LEVELS || cap > DEF_SLOT_COUNT) begin
      r.status = STAT_CFG;
    end else if (op == OP_LOCATE) begin
      base = tree_span(level, row);
      if (level >= tbl_levels || position >= row) r.status = STAT_OOB;
      else r.slot_index = SLOT_W'(base + position);
    end else if (op > OP_LOCATE || slot >= cap) begin
      r.status = STAT_OOB;
    end else begin
      hit = occ_map[slot];
      case (op)
        OP_ADD: begin
          if (hit) begin
            r.status = STAT_ALREADY;
          end else begin
            occ_map[slot] = 1'b1;
            occ_total++;
            r.slot_index = slot;
            r.byte_offset = off;
          end
        end
        OP_ADD_OR_GET: begin
          if (!hit) begin
            occ_map[slot] = 1'b1;
            occ_total++;
          end
          r.slot_index = slot;
          r.byte_offset = off;
        end
        OP_REMOVE: begin
          if (!hit) begin
            r.status = STAT_NOT_OCC;
          end else begin
            occ_map[slot] = 1'b0;
            occ_total--;
            r.slot_index = slot;
          end
        end
        OP_GET: begin
          if (!hit) begin
            r.status = STAT_NOT_OCC;
          end else begin
            r.slot_index = slot;
            r.byte_offset = off;
          end
        end
        default: begin
          r.slot_index = slot;
          r.present = hit;
        end
      endcase
    end
    r.occupied_count = occ_total;
    return r;
  endfunction

  function automatic stim_row_t op_row(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                       logic [LEVEL_W-1:0] level, logic [POS_W-1:0] position);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = '0;
    r.reg_data = '0;
    r.op = op;
    r.slot = slot;
    r.level = level;
    r.position = position;
    r.typed = 1'b0;
    r.want.status = STAT_OK;
    r.want.slot_index = '0;
    r.want.byte_offset = '0;
    r.want.present = 1'b0;
    r.want.occupied_count = '0;
    return r;
  endfunction

  function automatic stim_row_t chk_row(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                        logic [LEVEL_W-1:0] level, logic [POS_W-1:0] position,
                                        kts_status_t st, int unsigned sl, int unsigned off,
                                        bit pr, int unsigned cnt);
    stim_row_t r;
    r = op_row(op, slot, level, position);
    r.typed = 1'b1;
    r.want.status = st;
    r.want.slot_index = SLOT_W'(sl);
    r.want.byte_offset = OFFSET_W'(off);
    r.want.present = pr;
    r.want.occupied_count = COUNT_W'(cnt);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = op_row('0, '0, '0, '0);
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  // mostly in-bounds ops on a few hot slots so adds, gets and removes collide
  function automatic stim_row_t random_op_row();
    int unsigned cap;
    int unsigned row;
    int unsigned pick;
    int unsigned hot;
    int unsigned lv;
    int unsigned pos;
    bit          shape_ok;
    cap = tree_span(tbl_levels, row);
    shape_ok = (tbl_levels <= DEF_MAX_LEVELS) && (cap <= DEF_SLOT_COUNT);
    pick = $urandom_range(0, 99);
    if (pick < 70 && shape_ok && cap > 0) begin
      hot = (cap < 24) ? cap : 24;
      if ($urandom_range(0, 3) == 0) pos = $urandom_range(0, cap - 1);
      else pos = $urandom_range(0, hot - 1);
      return op_row(OP_W'($urandom_range(int'(OP_ADD), int'(OP_CONTAINS))), SLOT_W'(pos),
                    LEVEL_W'($urandom), POS_W'($urandom));
    end
    if (pick < 85 && shape_ok && tbl_levels > 0) begin
      lv = $urandom_range(0, tbl_levels - 1);
      void'(tree_span(lv, row));
      if (row == 0) pos = 0;
      else if ($urandom_range(0, 7) == 0) pos = row;
      else pos = $urandom_range(0, row - 1);
      return op_row(OP_LOCATE, SLOT_W'($urandom), LEVEL_W'(lv), POS_W'(pos));
    end
    return op_row(OP_W'($urandom_range(0, 7)), SLOT_W'($urandom), LEVEL_W'($urandom),
                  POS_W'($urandom));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    op_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_ARITY:  tbl_arity = data[ARITY_W-1:0];
      CFG_LEVELS: tbl_levels = data[LEVELS_W-1:0];
      CFG_EBYTES: tbl_ebytes = data[EBYTES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_op(stim_row_t r);
    slot_result_t predicted;
    cfg_ch.valid <= 1'b0;
    if (sent_items < 300) begin
      send_idle = 14;
      recv_idle = 72;
    end else if (sent_items < 600) begin
      send_idle = 72;
      recv_idle = 14;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(0, 99) < send_idle) begin
      op_ch.valid <= 1'b0;
      @(posedge clk);
    end
    op_ch.valid <= 1'b1;
    op_ch.op <= r.op;
    op_ch.slot <= r.slot;
    op_ch.level <= r.level;
    op_ch.position <= r.position;
    do @(posedge clk); while (!op_ch.ready);
    predicted = predict_slot_result(r.op, r.slot, r.level, r.position);
    if (r.typed) pending_results.push_back(r.want);
    else pending_results.push_back(predicted);
    sent_items++;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= FAIL_PRINT_MAX)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    slot_result_t w;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= FAIL_PRINT_MAX)
          $display("%0t: result beat with nothing expected, status %0d slot %0d",
                   $time, res_ch.status, res_ch.slot_index);
      end else begin
        w = pending_results.pop_front();
        check_field("status", w.status, res_ch.status);
        check_field("slot_index", w.slot_index, res_ch.slot_index);
        check_field("byte_offset", w.byte_offset, res_ch.byte_offset);
        check_field("present", w.present, res_ch.present);
        check_field("occupied_count", w.occupied_count, res_ch.occupied_count);
      end
    end
    res_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  initial begin : stimulus
    stim_row_t   dir_rows [$];
    int unsigned a;
    int unsigned l;
    int unsigned e;
    rst_n = 1'b0;
    op_ch.valid = 1'b0;
    op_ch.op = '0;
    op_ch.slot = '0;
    op_ch.level = '0;
    op_ch.position = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;

    // after reset the tree is a single root slot
    dir_rows.push_back(chk_row(OP_CONTAINS, 0, 0, 0, STAT_OK, 0, 0, 0, 0));
    dir_rows.push_back(chk_row(OP_GET, 0, 0, 0, STAT_NOT_OCC, 0, 0, 0, 0));
    dir_rows.push_back(chk_row(OP_REMOVE, 0, 0, 0, STAT_NOT_OCC, 0, 0, 0, 0));
    dir_rows.push_back(chk_row(OP_ADD, 0, 0, 0, STAT_OK, 0, 0, 0, 1));
    dir_rows.push_back(chk_row(OP_ADD, 0, 0, 0, STAT_ALREADY, 0, 0, 0, 1));
    dir_rows.push_back(chk_row(OP_ADD_OR_GET, 0, 15, 4095, STAT_OK, 0, 0, 0, 1));
    dir_rows.push_back(chk_row(OP_CONTAINS, 0, 0, 0, STAT_OK, 0, 0, 1, 1));
    dir_rows.push_back(chk_row(OP_GET, 4095, 0, 0, STAT_OOB, 0, 0, 0, 1));
    dir_rows.push_back(chk_row(3'd6, 0, 0, 0, STAT_OOB, 0, 0, 0, 1));
    dir_rows.push_back(chk_row(3'd7, 4095, 15, 4095, STAT_OOB, 0, 0, 0, 1));
    dir_rows.push_back(chk_row(OP_LOCATE, 4095, 0, 0, STAT_OK, 0, 0, 0, 1));
    dir_rows.push_back(chk_row(OP_LOCATE, 0, 15, 4095, STAT_OOB, 0, 0, 0, 1));
    // zero levels: nothing is in bounds
    dir_rows.push_back(cfg_row(CFG_LEVELS, 16'd0));
    dir_rows.push_back(chk_row(OP_ADD_OR_GET, 0, 0, 0, STAT_OOB, 0, 0, 0, 1));
    dir_rows.push_back(chk_row(OP_LOCATE, 0, 0, 0, STAT_OOB, 0, 0, 0, 1));
    // too many levels
    dir_rows.push_back(cfg_row(CFG_LEVELS, 16'd13));
    dir_rows.push_back(chk_row(OP_CONTAINS, 0, 0, 0, STAT_CFG, 0, 0, 0, 1));
    // deepest binary tree, largest element
    dir_rows.push_back(cfg_row(CFG_LEVELS, 16'd12));
    dir_rows.push_back(cfg_row(CFG_EBYTES, 16'hffff));
    dir_rows.push_back(op_row(OP_ADD, 4094, 0, 0));
    dir_rows.push_back(chk_row(OP_ADD, 4095, 0, 0, STAT_OOB, 0, 0, 0, 2));
    dir_rows.push_back(op_row(OP_LOCATE, 0, 11, 2047));
    dir_rows.push_back(chk_row(OP_LOCATE, 0, 11, 2048, STAT_OOB, 0, 0, 0, 2));
    // widest tree that still fits, then one slot too many
    dir_rows.push_back(cfg_row(CFG_ARITY, 16'd4095));
    dir_rows.push_back(cfg_row(CFG_LEVELS, 16'd2));
    dir_rows.push_back(op_row(OP_ADD, 4095, 0, 0));
    dir_rows.push_back(op_row(OP_LOCATE, 0, 1, 4094));
    dir_rows.push_back(cfg_row(CFG_ARITY, 16'd4096));
    dir_rows.push_back(op_row(OP_GET, 0, 0, 0));
    // degenerate arity and zero element size
    dir_rows.push_back(cfg_row(CFG_ARITY, 16'd0));
    dir_rows.push_back(cfg_row(CFG_LEVELS, 16'd12));
    dir_rows.push_back(cfg_row(CFG_EBYTES, 16'd0));
    dir_rows.push_back(op_row(OP_GET, 0, 0, 0));
    dir_rows.push_back(op_row(OP_LOCATE, 0, 1, 0));
    dir_rows.push_back(cfg_row(CFG_ARITY, 16'd1));
    dir_rows.push_back(op_row(OP_LOCATE, 0, 11, 0));
    dir_rows.push_back(op_row(OP_ADD, 11, 0, 0));
    // upper data bits are dropped by the register widths
    dir_rows.push_back(cfg_row(CFG_ARITY, 16'hffff));
    dir_rows.push_back(cfg_row(CFG_LEVELS, 16'hfff1));
    dir_rows.push_back(op_row(OP_REMOVE, 0, 0, 0));
    dir_rows.push_back(op_row(OP_CONTAINS, 4094, 0, 0));
    // slots left set beyond a shrunk tree come back when it grows
    dir_rows.push_back(cfg_row(CFG_ARITY, 16'd2));
    dir_rows.push_back(cfg_row(CFG_LEVELS, 16'd12));
    dir_rows.push_back(cfg_row(CFG_EBYTES, 16'd3));
    dir_rows.push_back(op_row(OP_CONTAINS, 4094, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      else send_op(dir_rows[i]);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < PRESETS) begin
        a = PRE_ARITY[ph];
        l = PRE_LEVELS[ph];
        e = PRE_EBYTES[ph];
      end else begin
        a = $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(2, 9);
        l = $urandom_range(0, 6);
        e = $urandom_range(0, 65535);
      end
      write_reg(CFG_ARITY, CFG_DATA_W'(a) | CFG_DATA_W'($urandom_range(0, 7) << ARITY_W));
      write_reg(CFG_LEVELS,
                CFG_DATA_W'(l) | CFG_DATA_W'($urandom_range(0, 4095) << LEVELS_W));
      write_reg(CFG_EBYTES, CFG_DATA_W'(e));
      repeat (ITEMS_PER_PHASE) send_op(random_op_row());
    end

    op_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: kary_tree_slot_table_unit.f
hw/rtl/kts_pkg.sv
hw/rtl/kts_if.sv
hw/rtl/kts_ram.sv
hw/rtl/kary_tree_slot_table_unit.sv
test/tb_top.sv
